@@ rtl/slst_pkg.sv @@
package slst_pkg;

  // Default depth of the sorted table
  localparam int unsigned DEF_CAPACITY = 16;

  // Operation codes
  localparam logic [1:0] OP_INSERT     = 2'd0;
  localparam logic [1:0] OP_REMOVE_MIN = 2'd1;
  localparam logic [1:0] OP_REMOVE_MAX = 2'd2;
  localparam logic [1:0] OP_REMOVE_EQ  = 2'd3;

  // Status codes
  localparam logic [1:0] STAT_DONE      = 2'd0;
  localparam logic [1:0] STAT_EMPTY     = 2'd1;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
  localparam logic [1:0] STAT_FULL      = 2'd3;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] removed_value;
    logic [4:0]         occupancy;
  } out_item_t;

  // Command broadcast to every cell
  typedef struct packed {
    logic               cmp;
    logic               apply;
    logic [1:0]         op;
    logic signed [31:0] value;
  } cell_cmd_t;

  // What a cell shows its neighbors and the controller
  typedef struct packed {
    logic               valid;
    logic               le;
    logic               lt;
    logic signed [31:0] data;
  } cell_link_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_APPLY
  } state_t;

endpackage

@@ rtl/slst_cell.sv @@
module slst_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  slst_pkg::cell_cmd_t  cmd,
  input  slst_pkg::cell_link_t left,
  input  slst_pkg::cell_link_t right,
  output slst_pkg::cell_link_t link
);
  import slst_pkg::*;

  logic               valid_r, valid_nxt;
  logic               le_r, lt_r;
  logic signed [31:0] data_r, data_nxt;

  // Pick the next entry from own value, left or right neighbor, or the new value
  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (cmd.apply) begin
      unique case (cmd.op)
        OP_INSERT: begin
          if (!le_r) begin
            if (left.le) begin
              valid_nxt = 1'b1;
              data_nxt  = cmd.value;
            end else begin
              valid_nxt = left.valid;
              data_nxt  = left.data;
            end
          end
        end
        OP_REMOVE_MIN: begin
          valid_nxt = right.valid;
          data_nxt  = right.data;
        end
        OP_REMOVE_MAX: begin
          valid_nxt = valid_r & right.valid;
        end
        OP_REMOVE_EQ: begin
          if (!lt_r) begin
            valid_nxt = right.valid;
            data_nxt  = right.data;
          end
        end
        default: ;
      endcase
    end
  end

  // Hold valid bit, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Advance data and capture compare flags
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (cmd.cmp) begin
      le_r <= valid_r && (data_r <= cmd.value);
      lt_r <= valid_r && (data_r < cmd.value);
    end
  end

  assign link.valid = valid_r;
  assign link.le    = le_r;
  assign link.lt    = lt_r;
  assign link.data  = data_r;

endmodule

@@ rtl/sorted_list_engine.sv @@
// Sorted list engine: a double-ended priority queue of signed 32-bit values
// kept in ascending order in a row of cells, up to CAPACITY entries.
// Input channel: drive in_item (op, value) and raise start while busy is low;
// the item is taken at that clock edge and busy rises for the work.
// Operations: insert in sorted place, remove smallest, remove largest, or
// remove the first entry equal to value.
// Result channel: out_valid strobes high for exactly one cycle with out_item
// (status, removed_value, occupancy). The receiver cannot stall; it must take
// the result in that cycle.
// Timing: the accepting edge moves to the compare state, where every cell
// compares its entry with the value; the apply state then resolves the
// match/tail across the row, shifts all cells at once and registers the
// result. Busy stays high until then, so no new item is taken while one is
// in work; start may be raised again in the cycle the result is shown.
// Reset (rst_n low, synchronous): the list is emptied, busy and out_valid drop.
module sorted_list_engine #(
  parameter int unsigned CAPACITY = slst_pkg::DEF_CAPACITY
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  slst_pkg::in_item_t  in_item,
  output logic                out_valid,
  output slst_pkg::out_item_t out_item
);
  import slst_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  state_t             state_r, state_nxt;
  in_item_t           item_r;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_item_r, out_item_nxt;
  logic               apply_ok;
  logic               full, empty, found;
  logic signed [31:0] tail_data;
  cell_cmd_t          cmd;
  cell_link_t         links [CAPACITY];
  cell_link_t         left_edge, right_edge;

  // Boundary cells: left edge always "at or below", right edge never valid
  assign left_edge  = '{valid: 1'b1, le: 1'b1, lt: 1'b1, data: '0};
  assign right_edge = '{valid: 1'b0, le: 1'b0, lt: 1'b0, data: '0};

  // Row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_link_t lnk_l, lnk_r;
    if (i == 0) begin : g_l0
      assign lnk_l = left_edge;
    end else begin : g_ln
      assign lnk_l = links[i-1];
    end
    if (i == CAPACITY - 1) begin : g_rl
      assign lnk_r = right_edge;
    end else begin : g_rn
      assign lnk_r = links[i+1];
    end
    slst_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .cmd   (cmd),
      .left  (lnk_l),
      .right (lnk_r),
      .link  (links[i])
    );
  end

  assign full  = (count_r == CNT_W'(CAPACITY));
  assign empty = (count_r == '0);

  // Collect match flag and tail value across the row
  always_comb begin
    found     = 1'b0;
    tail_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      found = found | (links[i].le & ~links[i].lt);
      if (i == CAPACITY - 1) begin
        tail_data = tail_data | (links[i].valid ? links[i].data : 32'sd0);
      end else begin
        tail_data = tail_data |
                    ((links[i].valid & ~links[i+1].valid) ? links[i].data : 32'sd0);
      end
    end
  end

  // Decide whether the operation changes the list
  always_comb begin
    if (item_r.op == OP_INSERT) begin
      apply_ok = !full;
    end else begin
      apply_ok = !empty && ((item_r.op != OP_REMOVE_EQ) || found);
    end
  end

  assign cmd.cmp   = (state_r == S_CMP);
  assign cmd.apply = (state_r == S_APPLY) && apply_ok;
  assign cmd.op    = item_r.op;
  assign cmd.value = item_r.value;

  // Next state, count and result
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        out_item_nxt.removed_value = '0;
        out_item_nxt.status        = STAT_DONE;
        if (apply_ok) begin
          if (item_r.op == OP_INSERT) begin
            count_nxt = count_r + CNT_W'(1);
          end else begin
            count_nxt = count_r - CNT_W'(1);
          end
        end
        priority if (item_r.op == OP_INSERT) begin
          if (full) begin
            out_item_nxt.status = STAT_FULL;
          end
        end else if (empty) begin
          out_item_nxt.status = STAT_EMPTY;
        end else if (item_r.op == OP_REMOVE_MIN) begin
          out_item_nxt.removed_value = links[0].data;
        end else if (item_r.op == OP_REMOVE_MAX) begin
          out_item_nxt.removed_value = tail_data;
        end else if (found) begin
          out_item_nxt.removed_value = item_r.value;
        end else begin
          out_item_nxt.status = STAT_NOT_FOUND;
        end
        out_item_nxt.occupancy = 5'(count_nxt);
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: capture item on accept, hold result
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      item_r <= in_item;
    end
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

@@ tb/sv/sorted_list_engine_tb.sv @@
module sorted_list_engine_tb;
  import slst_pkg::*;

  localparam int CAPACITY     = DEF_CAPACITY;
  localparam int RANDOM_ITEMS = 1150;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int REPORT_MAX   = 10;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  // Shadow copy of the table, kept in ascending order
  logic signed [31:0] shadow_list[$];
  out_item_t          expected_results[$];
  out_item_t          want_item;
  int                 fault_count = 0;
  int                 cycle_count = 0;

  sorted_list_engine #(.CAPACITY(CAPACITY)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // Generate a 20-unit clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Apply one operation to the shadow list and return the result it gives
  function automatic out_item_t apply_list_op(in_item_t it);
    out_item_t r;
    int        pos;
    r.status        = STAT_DONE;
    r.removed_value = '0;
    pos             = 0;
    if (it.op == OP_INSERT) begin
      if (shadow_list.size() >= CAPACITY) begin
        r.status = STAT_FULL;
      end else begin
        // Equal values go after the ones already held
        while (pos < shadow_list.size() && shadow_list[pos] <= it.value) pos++;
        shadow_list.insert(pos, it.value);
      end
    end else if (shadow_list.size() == 0) begin
      r.status = STAT_EMPTY;
    end else begin
      case (it.op)
        OP_REMOVE_MIN: r.removed_value = shadow_list.pop_front();
        OP_REMOVE_MAX: r.removed_value = shadow_list.pop_back();
        default: begin
          while (pos < shadow_list.size() && shadow_list[pos] != it.value) pos++;
          if (pos >= shadow_list.size()) begin
            r.status = STAT_NOT_FOUND;
          end else begin
            r.removed_value = shadow_list[pos];
            shadow_list.delete(pos);
          end
        end
      endcase
    end
    r.occupancy = 5'(shadow_list.size());
    return r;
  endfunction

  // Pick a value: small range for collisions, extremes, held entries, or anything
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(9))
      0, 1, 2: return int'($urandom_range(16)) - 8;
      3: begin
        case ($urandom_range(3))
          0:       return 32'sh8000_0000;
          1:       return 32'sh7fff_ffff;
          2:       return 32'sh0000_0000;
          default: return -32'sd1;
        endcase
      end
      4, 5: begin
        if (shadow_list.size() != 0) return shadow_list[$urandom_range(shadow_list.size() - 1)];
        return $urandom();
      end
      default: return $urandom();
    endcase
  endfunction

  // Hold an item on the input until it is taken, then record its result
  task automatic send_item(logic [1:0] op, logic signed [31:0] value);
    in_item_t it;
    it.op    = op;
    it.value = value;
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy !== 1'b0);
    expected_results.push_back(apply_list_op(it));
  endtask

  // Drop start for a number of cycles
  task automatic idle_gap(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Every removal on an empty list
  task automatic test_empty_list();
    send_item(OP_REMOVE_MIN, 32'sd5);
    send_item(OP_REMOVE_MAX, -32'sd5);
    send_item(OP_REMOVE_EQ, 32'sd0);
  endtask

  // Extreme values, duplicates, matching and missing removals
  task automatic test_extreme_values();
    send_item(OP_INSERT, 32'sh8000_0000);
    send_item(OP_INSERT, 32'sh7fff_ffff);
    send_item(OP_INSERT, 32'sd0);
    idle_gap(2);
    send_item(OP_INSERT, -32'sd1);
    send_item(OP_INSERT, 32'sd0);
    send_item(OP_REMOVE_EQ, 32'sd0);
    idle_gap(1);
    send_item(OP_REMOVE_EQ, 32'sd12345);
    send_item(OP_REMOVE_MIN, 32'sh7fff_ffff);
    send_item(OP_REMOVE_MAX, 32'sh8000_0000);
  endtask

  // Fill the table, reject one more insert, then take entries back out
  task automatic test_full_list();
    while (shadow_list.size() < CAPACITY) send_item(OP_INSERT, $urandom());
    send_item(OP_INSERT, 32'sd7);
    send_item(OP_REMOVE_EQ, shadow_list[CAPACITY / 2]);
    send_item(OP_REMOVE_MAX, 32'sd0);
  endtask

  // Random bursts; phases lean toward filling or draining the table
  task automatic test_random_traffic();
    int         sent;
    int         burst;
    int         insert_pct;
    logic [1:0] op;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      insert_pct = ((sent / 64) % 2 == 0) ? 70 : 30;
      burst      = $urandom_range(24, 1);
      repeat (burst) begin
        if ($urandom_range(99) < insert_pct) begin
          op = OP_INSERT;
        end else begin
          case ($urandom_range(2))
            0:       op = OP_REMOVE_MIN;
            1:       op = OP_REMOVE_MAX;
            default: op = OP_REMOVE_EQ;
          endcase
        end
        send_item(op, pick_value());
        sent++;
      end
      if ($urandom_range(3) != 0) idle_gap($urandom_range(12, 1));
    end
  endtask

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (expected_results.size() == 0) begin
        fault_count++;
        if (fault_count <= REPORT_MAX)
          $display("unexpected result: status %0d removed %0d occupancy %0d",
                   out_item.status, out_item.removed_value, out_item.occupancy);
      end else begin
        want_item = expected_results.pop_front();
        if (out_item.status !== want_item.status ||
            out_item.removed_value !== want_item.removed_value ||
            out_item.occupancy !== want_item.occupancy) begin
          fault_count++;
          if (fault_count <= REPORT_MAX)
            $display("mismatch: expected status %0d removed %0d occupancy %0d, got %0d %0d %0d",
                     want_item.status, want_item.removed_value, want_item.occupancy,
                     out_item.status, out_item.removed_value, out_item.occupancy);
        end
      end
    end
  end

  // Reset, run the tests in turn, drain and report
  initial begin
    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_list();
    test_extreme_values();
    test_full_list();
    test_random_traffic();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fault_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
